[design/baic_pkg.sv]
package baic_pkg;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int TIMER_W  = 16;
    localparam int MODE_W   = 3;
    localparam int COUNT_W  = 5;
    localparam int SUM_W    = 17;

    // Default averaging depth
    localparam int SAMPLES_DEFAULT = 20;

    // APB port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    // Mode codes
    localparam mode_t MODE_PREHEAT  = 3'd0;
    localparam mode_t MODE_STANDBY  = 3'd1;
    localparam mode_t MODE_SAMPLING = 3'd2;
    localparam mode_t MODE_PASS     = 3'd3;
    localparam mode_t MODE_FAIL     = 3'd4;
    localparam mode_t MODE_RUNNING  = 3'd5;

    // Register indexes (byte address = 4 * index)
    localparam reg_idx_t REG_THRESHOLD = 3'd0;
    localparam reg_idx_t REG_PREHEAT   = 3'd1;
    localparam reg_idx_t REG_DEBOUNCE  = 3'd2;
    localparam reg_idx_t REG_INTERVAL  = 3'd3;
    localparam reg_idx_t REG_PERIOD    = 3'd4;
    localparam reg_idx_t REG_ALARM_ON  = 3'd5;
    localparam reg_idx_t REG_BEEP      = 3'd6;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd2000;
    localparam logic [TIMER_W-1:0]  PREHEAT_RST   = 16'd10000;
    localparam logic [TIMER_W-1:0]  DEBOUNCE_RST  = 16'd60;
    localparam logic [TIMER_W-1:0]  INTERVAL_RST  = 16'd50;
    localparam logic [TIMER_W-1:0]  PERIOD_RST    = 16'd500;
    localparam logic [TIMER_W-1:0]  ALARM_ON_RST  = 16'd220;
    localparam logic [TIMER_W-1:0]  BEEP_RST      = 16'd180;

endpackage

[design/baic_if.sv]
// One-millisecond tick request: raw button levels and sensor reading
interface baic_tick_if;
    logic                          valid;
    logic                          ready;
    logic                          test_level;
    logic                          start_level;
    logic [baic_pkg::SAMPLE_W-1:0] sensor_sample;

    modport source (output valid, output test_level, output start_level,
                    output sensor_sample, input ready);
    modport sink (input valid, input test_level, input start_level,
                  input sensor_sample, output ready);
endinterface

// Per-tick result request
interface baic_result_if;
    logic                          valid;
    logic                          ready;
    logic [baic_pkg::MODE_W-1:0]   mode;
    logic                          lock_open;
    logic                          led_red;
    logic                          led_green;
    logic                          led_yellow;
    logic                          buzzer;
    logic [baic_pkg::SAMPLE_W-1:0] measured_level;
    logic                          verdict_strobe;

    modport source (output valid, output mode, output lock_open, output led_red,
                    output led_green, output led_yellow, output buzzer,
                    output measured_level, output verdict_strobe, input ready);
    modport sink (input valid, input mode, input lock_open, input led_red,
                  input led_green, input led_yellow, input buzzer,
                  input measured_level, input verdict_strobe, output ready);
endinterface

[design/breath_alcohol_interlock_controller.sv]
// Breath alcohol interlock controller. Each tick request carries the raw active-low
// test and start button levels and one 12-bit sensor reading; each produces exactly
// one result request with the mode, lock, LED, buzzer, last averaged reading and a
// verdict strobe, all reflecting the state after that tick. The block takes one tick
// per clock cycle while the result side keeps up: a tick lands in an input register,
// and once the output register is free the controller state is updated and the
// result is written to the output register; a stalled result backs up into the
// input register and then holds ready low. The average of SAMPLES readings is
// formed by one constant reciprocal multiply. There is no clearing pass after reset.
// Registers sit on an APB port at byte address 4*index and should only be written
// while no tick is in flight.
module breath_alcohol_interlock_controller #(
    parameter int SAMPLES = baic_pkg::SAMPLES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    baic_tick_if.sink                         tick,
    baic_result_if.source                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [baic_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [baic_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [baic_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int SAMPLE_W = baic_pkg::SAMPLE_W;
    localparam int TIMER_W  = baic_pkg::TIMER_W;
    localparam int COUNT_W  = baic_pkg::COUNT_W;
    localparam int SUM_W    = baic_pkg::SUM_W;
    localparam int DATA_W   = baic_pkg::APB_DATA_W;

    // Reciprocal for sum / SAMPLES: exact for any 17-bit sum and SAMPLES below 32
    localparam int DIV_SHIFT = SUM_W + COUNT_W;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((longint'(1) << DIV_SHIFT) + longint'(SAMPLES) - 1) / longint'(SAMPLES));
    localparam logic [COUNT_W-1:0] SAMPLES_C = COUNT_W'(SAMPLES);
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // Configuration registers
    logic [SAMPLE_W-1:0] threshold_reg;
    logic [TIMER_W-1:0]  preheat_reg;
    logic [TIMER_W-1:0]  debounce_reg;
    logic [TIMER_W-1:0]  interval_reg;
    logic [TIMER_W-1:0]  period_reg;
    logic [TIMER_W-1:0]  alarm_on_reg;
    logic [TIMER_W-1:0]  beep_ticks_reg;

    baic_pkg::reg_idx_t  reg_idx;
    logic                cfg_write;

    assign reg_idx   = paddr[baic_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= baic_pkg::THRESHOLD_RST;
            preheat_reg    <= baic_pkg::PREHEAT_RST;
            debounce_reg   <= baic_pkg::DEBOUNCE_RST;
            interval_reg   <= baic_pkg::INTERVAL_RST;
            period_reg     <= baic_pkg::PERIOD_RST;
            alarm_on_reg   <= baic_pkg::ALARM_ON_RST;
            beep_ticks_reg <= baic_pkg::BEEP_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                baic_pkg::REG_THRESHOLD: threshold_reg  <= pwdata[SAMPLE_W-1:0];
                baic_pkg::REG_PREHEAT:   preheat_reg    <= pwdata[TIMER_W-1:0];
                baic_pkg::REG_DEBOUNCE:  debounce_reg   <= pwdata[TIMER_W-1:0];
                baic_pkg::REG_INTERVAL:  interval_reg   <= pwdata[TIMER_W-1:0];
                baic_pkg::REG_PERIOD:    period_reg     <= pwdata[TIMER_W-1:0];
                baic_pkg::REG_ALARM_ON:  alarm_on_reg   <= pwdata[TIMER_W-1:0];
                baic_pkg::REG_BEEP:      beep_ticks_reg <= pwdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_idx)
            baic_pkg::REG_THRESHOLD: prdata = DATA_W'(threshold_reg);
            baic_pkg::REG_PREHEAT:   prdata = DATA_W'(preheat_reg);
            baic_pkg::REG_DEBOUNCE:  prdata = DATA_W'(debounce_reg);
            baic_pkg::REG_INTERVAL:  prdata = DATA_W'(interval_reg);
            baic_pkg::REG_PERIOD:    prdata = DATA_W'(period_reg);
            baic_pkg::REG_ALARM_ON:  prdata = DATA_W'(alarm_on_reg);
            baic_pkg::REG_BEEP:      prdata = DATA_W'(beep_ticks_reg);
            default:                 prdata = '0;
        endcase
    end

    // Input register stage
    logic                in_vld_reg;
    logic                in_test_reg;
    logic                in_start_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                out_vld_reg;
    logic                fire;

    assign fire       = in_vld_reg && (!out_vld_reg || result.ready);
    assign tick.ready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (tick.valid && tick.ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_test_reg   <= tick.test_level;
            in_start_reg  <= tick.start_level;
            in_sample_reg <= tick.sensor_sample;
        end
    end

    // Controller state
    baic_pkg::mode_t     mode_reg, mode_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [1:0]          last_reg, last_next;
    logic [1:0]          stable_reg, stable_next;
    logic [TIMER_W-1:0]  since_reg [2];
    logic [TIMER_W-1:0]  since_next [2];
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  taken_reg, taken_next;
    logic [TIMER_W-1:0]  phase_reg, phase_next;
    logic [TIMER_W-1:0]  beep_reg, beep_next;
    logic [SAMPLE_W-1:0] measured_reg, measured_next;

    // Debouncers: index 0 test, index 1 start
    logic [1:0] level;
    logic [1:0] settle;
    logic [1:0] press;

    assign level = {in_start_reg, in_test_reg};

    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            last_next[b] = level[b];
            if (level[b] != last_reg[b])
            begin
                since_next[b] = '0;
            end
            else if (since_reg[b] != TIMER_MAX)
            begin
                since_next[b] = since_reg[b] + 1'b1;
            end
            else
            begin
                since_next[b] = since_reg[b];
            end
            settle[b]      = (since_next[b] > debounce_reg) && (level[b] != stable_reg[b]);
            stable_next[b] = settle[b] ? level[b] : stable_reg[b];
            press[b]       = settle[b] && !level[b];
        end
    end

    // Alarm phase, free running; zero period acts as one
    logic [TIMER_W-1:0] period_eff;
    logic [TIMER_W:0]   phase_inc;

    assign period_eff = (period_reg == '0) ? TIMER_W'(1) : period_reg;
    assign phase_inc  = {1'b0, phase_reg} + 1'b1;
    assign phase_next = (phase_inc >= {1'b0, period_eff}) ? '0 : phase_inc[TIMER_W-1:0];

    // Sampling datapath: accumulate, then average by reciprocal multiply
    logic [TIMER_W-1:0]  interval_eff;
    logic                take;
    logic [SUM_W-1:0]    sum_add;
    logic [COUNT_W-1:0]  taken_add;
    logic [TIMER_W-1:0]  timer_inc;
    logic [PROD_W-1:0]   avg_prod;
    logic [SAMPLE_W-1:0] average;

    assign interval_eff = (interval_reg == '0) ? TIMER_W'(1) : interval_reg;
    assign take         = (timer_reg == '0) && (taken_reg < SAMPLES_C);
    assign sum_add      = take ? sum_reg + SUM_W'(in_sample_reg) : sum_reg;
    assign taken_add    = take ? taken_reg + 1'b1 : taken_reg;
    assign timer_inc    = timer_reg + 1'b1;
    assign avg_prod     = PROD_W'(sum_add) * PROD_W'(RECIP);
    assign average      = avg_prod[DIV_SHIFT +: SAMPLE_W];

    logic strobe;
    logic buzz;

    // Mode transitions
    always_comb
    begin
        mode_next     = mode_reg;
        timer_next    = timer_reg;
        sum_next      = sum_reg;
        taken_next    = taken_reg;
        beep_next     = beep_reg;
        measured_next = measured_reg;
        strobe        = 1'b0;

        unique case (mode_reg)
            baic_pkg::MODE_PREHEAT:
            begin
                if (timer_reg >= preheat_reg)
                begin
                    mode_next  = baic_pkg::MODE_STANDBY;
                    timer_next = '0;
                end
                else if (timer_reg != TIMER_MAX)
                begin
                    timer_next = timer_inc;
                end
            end
            baic_pkg::MODE_STANDBY, baic_pkg::MODE_FAIL:
            begin
                if (press[0])
                begin
                    mode_next  = baic_pkg::MODE_SAMPLING;
                    timer_next = '0;
                    sum_next   = '0;
                    taken_next = '0;
                end
            end
            baic_pkg::MODE_SAMPLING:
            begin
                sum_next   = sum_add;
                taken_next = taken_add;
                if (timer_inc >= interval_eff)
                begin
                    timer_next = '0;
                    if (taken_add >= SAMPLES_C)
                    begin
                        measured_next = average;
                        strobe        = 1'b1;
                        if (average < threshold_reg)
                        begin
                            mode_next = baic_pkg::MODE_PASS;
                            beep_next = beep_ticks_reg;
                        end
                        else
                        begin
                            mode_next = baic_pkg::MODE_FAIL;
                        end
                    end
                end
                else
                begin
                    timer_next = timer_inc;
                end
            end
            baic_pkg::MODE_PASS:
            begin
                priority if (beep_reg != '0)
                begin
                    beep_next = beep_reg - 1'b1;
                end
                else if (press[0])
                begin
                    mode_next  = baic_pkg::MODE_SAMPLING;
                    timer_next = '0;
                    sum_next   = '0;
                    taken_next = '0;
                end
                else if (press[1])
                begin
                    mode_next = baic_pkg::MODE_RUNNING;
                end
                else
                begin
                    mode_next = mode_reg;
                end
            end
            baic_pkg::MODE_RUNNING:
            begin
                if (press[1])
                begin
                    mode_next = baic_pkg::MODE_STANDBY;
                end
            end
            default:
            begin
                mode_next  = baic_pkg::MODE_PREHEAT;
                timer_next = '0;
            end
        endcase
    end

    // Buzzer: beep in pass, pulsing in fail from the phase before this tick
    always_comb
    begin
        if (mode_next == baic_pkg::MODE_PASS)
        begin
            buzz = (beep_next != '0);
        end
        else if (mode_next == baic_pkg::MODE_FAIL)
        begin
            buzz = (phase_reg < alarm_on_reg);
        end
        else
        begin
            buzz = 1'b0;
        end
    end

    // State update, one tick per fire
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= baic_pkg::MODE_PREHEAT;
            timer_reg     <= '0;
            last_reg      <= '1;
            stable_reg    <= '1;
            since_reg[0]  <= '0;
            since_reg[1]  <= '0;
            sum_reg       <= '0;
            taken_reg     <= '0;
            phase_reg     <= '0;
            beep_reg      <= '0;
            measured_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            timer_reg     <= timer_next;
            last_reg      <= last_next;
            stable_reg    <= stable_next;
            since_reg[0]  <= since_next[0];
            since_reg[1]  <= since_next[1];
            sum_reg       <= sum_next;
            taken_reg     <= taken_next;
            phase_reg     <= phase_next;
            beep_reg      <= beep_next;
            measured_reg  <= measured_next;
        end
    end

    // Result register
    baic_pkg::mode_t     res_mode_reg;
    logic                res_lock_reg;
    logic                res_red_reg;
    logic                res_green_reg;
    logic                res_yellow_reg;
    logic                res_buzz_reg;
    logic [SAMPLE_W-1:0] res_measured_reg;
    logic                res_strobe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_mode_reg     <= mode_next;
            res_lock_reg     <= (mode_next == baic_pkg::MODE_RUNNING);
            res_red_reg      <= (mode_next == baic_pkg::MODE_FAIL);
            res_green_reg    <= (mode_next == baic_pkg::MODE_PASS) ||
                                (mode_next == baic_pkg::MODE_RUNNING);
            res_yellow_reg   <= (mode_next == baic_pkg::MODE_PREHEAT) ||
                                (mode_next == baic_pkg::MODE_SAMPLING);
            res_buzz_reg     <= buzz;
            res_measured_reg <= measured_next;
            res_strobe_reg   <= strobe;
        end
    end

    assign result.valid          = out_vld_reg;
    assign result.mode           = res_mode_reg;
    assign result.lock_open      = res_lock_reg;
    assign result.led_red        = res_red_reg;
    assign result.led_green      = res_green_reg;
    assign result.led_yellow     = res_yellow_reg;
    assign result.buzzer         = res_buzz_reg;
    assign result.measured_level = res_measured_reg;
    assign result.verdict_strobe = res_strobe_reg;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import baic_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int REPORT_MAX  = 10;
    localparam int DRAIN_MAX   = 2000;

    // One tick request as sent
    typedef struct packed {
        logic                test_level;
        logic                start_level;
        logic [SAMPLE_W-1:0] sensor_sample;
    } tick_t;

    // One status request as returned
    typedef struct packed {
        mode_t               mode;
        logic                lock_open;
        logic                led_red;
        logic                led_green;
        logic                led_yellow;
        logic                buzzer;
        logic [SAMPLE_W-1:0] measured_level;
        logic                verdict_strobe;
    } status_t;

    // How the sensor readings of a breath are shaped
    typedef enum int {
        SENSE_ANY,
        SENSE_CLEAN,
        SENSE_DRUNK,
        SENSE_EDGE,
        SENSE_RAILS,
        SENSE_AT_LIMIT,
        SENSE_UNDER_LIMIT
    } sense_style_e;

    // Interlock predictor plus the queue of status requests it still owes
    class interlock_checker;
        logic [SAMPLE_W-1:0] threshold;
        logic [TIMER_W-1:0]  preheat_len;
        logic [TIMER_W-1:0]  debounce_len;
        logic [TIMER_W-1:0]  interval_len;
        logic [TIMER_W-1:0]  period_len;
        logic [TIMER_W-1:0]  alarm_on_len;
        logic [TIMER_W-1:0]  beep_len;

        mode_t               mode_q;
        logic [TIMER_W-1:0]  mode_timer;
        logic [1:0]          last_read;
        logic [1:0]          stable_level;
        logic [TIMER_W-1:0]  since_change [2];
        logic [SUM_W-1:0]    sum_q;
        logic [COUNT_W-1:0]  taken_q;
        logic [TIMER_W-1:0]  alarm_phase;
        logic [TIMER_W-1:0]  beep_left;
        logic [SAMPLE_W-1:0] measured_q;

        status_t pending_status [$];
        int      mismatches;
        int      checked;
        int      passes;
        int      fails;
        int      unlocks;

        function new();
            threshold       = THRESHOLD_RST;
            preheat_len     = PREHEAT_RST;
            debounce_len    = DEBOUNCE_RST;
            interval_len    = INTERVAL_RST;
            period_len      = PERIOD_RST;
            alarm_on_len    = ALARM_ON_RST;
            beep_len        = BEEP_RST;
            mode_q          = MODE_PREHEAT;
            mode_timer      = '0;
            last_read       = 2'b11;
            stable_level    = 2'b11;
            since_change[0] = '0;
            since_change[1] = '0;
            sum_q           = '0;
            taken_q         = '0;
            alarm_phase     = '0;
            beep_left       = '0;
            measured_q      = '0;
            mismatches      = 0;
            checked         = 0;
            passes          = 0;
            fails           = 0;
            unlocks         = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("MISMATCH: %s", msg);
        endfunction

        function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_THRESHOLD: threshold    = value[SAMPLE_W-1:0];
                REG_PREHEAT:   preheat_len  = value[TIMER_W-1:0];
                REG_DEBOUNCE:  debounce_len = value[TIMER_W-1:0];
                REG_INTERVAL:  interval_len = value[TIMER_W-1:0];
                REG_PERIOD:    period_len   = value[TIMER_W-1:0];
                REG_ALARM_ON:  alarm_on_len = value[TIMER_W-1:0];
                REG_BEEP:      beep_len     = value[TIMER_W-1:0];
                default: ;
            endcase
        endfunction

        // Debouncer; returns 1 when the level newly settles low
        function bit button_press(int b, logic level);
            if (level != last_read[b])
            begin
                last_read[b]    = level;
                since_change[b] = '0;
            end
            else if (since_change[b] != '1)
                since_change[b]++;
            if (since_change[b] > debounce_len && level != stable_level[b])
            begin
                stable_level[b] = level;
                return level == 1'b0;
            end
            return 1'b0;
        endfunction

        function void start_breath();
            mode_q     = MODE_SAMPLING;
            mode_timer = '0;
            sum_q      = '0;
            taken_q    = '0;
        endfunction

        // Advance one tick and queue the status it must produce
        function void note_tick(tick_t t);
            status_t s;
            bit      test_press;
            bit      start_press;
            int      interval;
            int      period;
            int      phase;
            mode_t   prev_mode;
            test_press  = button_press(0, t.test_level);
            start_press = button_press(1, t.start_level);
            interval    = (interval_len == 0) ? 1 : int'(interval_len);
            period      = (period_len == 0) ? 1 : int'(period_len);
            phase       = int'(alarm_phase);
            prev_mode   = mode_q;
            s           = '0;

            case (mode_q)
                MODE_PREHEAT:
                begin
                    if (mode_timer >= preheat_len)
                    begin
                        mode_q     = MODE_STANDBY;
                        mode_timer = '0;
                    end
                    else if (mode_timer != '1)
                        mode_timer++;
                end
                MODE_STANDBY:
                begin
                    if (test_press)
                        start_breath();
                end
                MODE_SAMPLING:
                begin
                    if (mode_timer == 0 && taken_q < SAMPLES_DEFAULT)
                    begin
                        sum_q += SUM_W'(t.sensor_sample);
                        taken_q++;
                    end
                    mode_timer++;
                    if (mode_timer >= interval)
                    begin
                        mode_timer = '0;
                        if (taken_q >= SAMPLES_DEFAULT)
                        begin
                            measured_q       = SAMPLE_W'(sum_q / SAMPLES_DEFAULT);
                            s.verdict_strobe = 1'b1;
                            if (measured_q < threshold)
                            begin
                                mode_q    = MODE_PASS;
                                beep_left = beep_len;
                                passes++;
                            end
                            else
                            begin
                                mode_q = MODE_FAIL;
                                fails++;
                            end
                        end
                    end
                end
                MODE_PASS:
                begin
                    // presses only count once the beep is over; test wins over start
                    if (beep_left != 0)
                        beep_left--;
                    else if (test_press)
                        start_breath();
                    else if (start_press)
                        mode_q = MODE_RUNNING;
                end
                MODE_FAIL:
                begin
                    if (test_press)
                        start_breath();
                end
                MODE_RUNNING:
                begin
                    if (start_press)
                        mode_q = MODE_STANDBY;
                end
                default:
                begin
                    mode_q     = MODE_PREHEAT;
                    mode_timer = '0;
                end
            endcase

            if (mode_q == MODE_RUNNING && prev_mode != MODE_RUNNING)
                unlocks++;

            s.mode           = mode_q;
            s.lock_open      = (mode_q == MODE_RUNNING);
            s.led_red        = (mode_q == MODE_FAIL);
            s.led_green      = (mode_q == MODE_PASS || mode_q == MODE_RUNNING);
            s.led_yellow     = (mode_q == MODE_PREHEAT || mode_q == MODE_SAMPLING);
            s.measured_level = measured_q;
            if (mode_q == MODE_PASS)
                s.buzzer = (beep_left != 0);
            else if (mode_q == MODE_FAIL)
                s.buzzer = (phase < alarm_on_len);

            // alarm phase free-runs in every mode
            alarm_phase = (phase + 1 >= period) ? '0 : TIMER_W'(phase + 1);
            pending_status.push_back(s);
        endfunction

        function void check_result(status_t got);
            status_t want;
            string   diff;
            if (pending_status.size() == 0)
            begin
                flag($sformatf("status with no tick waiting (mode %0d)", got.mode));
                return;
            end
            want = pending_status.pop_front();
            diff = "";
            if (got.mode !== want.mode)
                diff = {diff, $sformatf(" mode exp %0d got %0d", want.mode, got.mode)};
            if (got.lock_open !== want.lock_open)
                diff = {diff, $sformatf(" lock exp %b got %b", want.lock_open, got.lock_open)};
            if (got.led_red !== want.led_red)
                diff = {diff, $sformatf(" red exp %b got %b", want.led_red, got.led_red)};
            if (got.led_green !== want.led_green)
                diff = {diff, $sformatf(" green exp %b got %b", want.led_green, got.led_green)};
            if (got.led_yellow !== want.led_yellow)
                diff = {diff, $sformatf(" yellow exp %b got %b", want.led_yellow,
                                        got.led_yellow)};
            if (got.buzzer !== want.buzzer)
                diff = {diff, $sformatf(" buzzer exp %b got %b", want.buzzer, got.buzzer)};
            if (got.measured_level !== want.measured_level)
                diff = {diff, $sformatf(" level exp %0d got %0d", want.measured_level,
                                        got.measured_level)};
            if (got.verdict_strobe !== want.verdict_strobe)
                diff = {diff, $sformatf(" strobe exp %b got %b", want.verdict_strobe,
                                        got.verdict_strobe)};
            if (diff != "")
                flag($sformatf("status #%0d:%s", checked, diff));
            checked++;
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    baic_tick_if   tick_if ();
    baic_result_if status_if ();

    breath_alcohol_interlock_controller #(
        .SAMPLES (SAMPLES_DEFAULT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_if),
        .result  (status_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    interlock_checker chk;
    int               ticks_sent = 0;
    int               cycles = 0;
    int               settings_applied = 0;
    bit               no_gaps = 1'b0;
    bit               no_stalls = 1'b0;
    // current settings, used to shape button gestures and sensor readings
    int               cur_threshold = THRESHOLD_RST;
    int               cur_debounce = DEBOUNCE_RST;
    int               cur_interval = INTERVAL_RST;
    int               cur_beep = BEEP_RST;
    sense_style_e     sensor_style = SENSE_ANY;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d ticks sent", cycles, ticks_sent);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Status side: random stalls, check every accepted request
    initial
    begin : status_sink
        int      stall;
        status_t got;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                no_stalls = !no_stalls;
            stall = no_stalls ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                status_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            status_if.ready <= 1'b1;
            @(posedge clk);
            while (!status_if.valid)
                @(posedge clk);
            got.mode           = status_if.mode;
            got.lock_open      = status_if.lock_open;
            got.led_red        = status_if.led_red;
            got.led_green      = status_if.led_green;
            got.led_yellow     = status_if.led_yellow;
            got.buzzer         = status_if.buzzer;
            got.measured_level = status_if.measured_level;
            got.verdict_strobe = status_if.verdict_strobe;
            chk.check_result(got);
        end
    end

    // Send one tick request after a random gap; returns at the accepting edge
    task automatic send_tick(input logic test_level, input logic start_level,
                             input logic [SAMPLE_W-1:0] sample);
        int    gap;
        tick_t t;
        if ($urandom_range(0, 39) == 0)
            no_gaps = !no_gaps;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_if.valid         <= 1'b1;
        tick_if.test_level    <= test_level;
        tick_if.start_level   <= start_level;
        tick_if.sensor_sample <= sample;
        t.test_level    = test_level;
        t.start_level   = start_level;
        t.sensor_sample = sample;
        @(posedge clk);
        while (!tick_if.ready)
            @(posedge clk);
        chk.note_tick(t);
        ticks_sent++;
    endtask

    // Stop sending and let every owed status drain
    task automatic wait_idle();
        int waited;
        waited = 0;
        tick_if.valid <= 1'b0;
        while (chk.pending_status.size() != 0 && waited < DRAIN_MAX)
        begin
            @(posedge clk);
            waited++;
        end
        if (chk.pending_status.size() != 0)
        begin
            chk.flag($sformatf("%0d status requests never arrived",
                               chk.pending_status.size()));
            chk.pending_status.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    // APB write, then read back
    task automatic write_reg(input reg_idx_t idx, input logic [TIMER_W-1:0] value);
        logic [APB_DATA_W-1:0] data;
        logic [APB_DATA_W-1:0] readback_want;
        // upper bits carry junk half the time; the register must drop them
        data = $urandom_range(0, 1) ? $urandom() : '0;
        if (idx == REG_THRESHOLD)
        begin
            data[SAMPLE_W-1:0] = value[SAMPLE_W-1:0];
            readback_want      = APB_DATA_W'(value[SAMPLE_W-1:0]);
        end
        else
        begin
            data[TIMER_W-1:0] = value;
            readback_want     = APB_DATA_W'(value);
        end

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        chk.set_reg(idx, data);

        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== readback_want)
            chk.flag($sformatf("register %0d readback exp %0d got %0d", idx,
                               readback_want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input int thr, input int pre, input int deb, input int intv,
                                  input int per, input int on_len, input int beep);
        wait_idle();
        write_reg(REG_THRESHOLD, TIMER_W'(thr));
        write_reg(REG_PREHEAT, TIMER_W'(pre));
        write_reg(REG_DEBOUNCE, TIMER_W'(deb));
        write_reg(REG_INTERVAL, TIMER_W'(intv));
        write_reg(REG_PERIOD, TIMER_W'(per));
        write_reg(REG_ALARM_ON, TIMER_W'(on_len));
        write_reg(REG_BEEP, TIMER_W'(beep));
        cur_threshold = thr;
        cur_debounce  = deb;
        cur_interval  = (intv == 0) ? 1 : intv;
        cur_beep      = beep;
        settings_applied++;
    endtask

    function automatic logic [SAMPLE_W-1:0] next_sample();
        int v;
        case (sensor_style)
            SENSE_CLEAN:       v = (cur_threshold == 0) ? 0 : $urandom_range(0, cur_threshold - 1);
            SENSE_DRUNK:       v = $urandom_range(cur_threshold, 4095);
            SENSE_EDGE:        v = cur_threshold + $urandom_range(0, 8) - 4;
            SENSE_RAILS:       v = $urandom_range(0, 1) ? 4095 : 0;
            SENSE_AT_LIMIT:    v = cur_threshold;
            SENSE_UNDER_LIMIT: v = cur_threshold - 1;
            default:           v = $urandom_range(0, 4095);
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[SAMPLE_W-1:0];
    endfunction

    // Low time for a press; now and then one tick short of settling
    function automatic int press_len();
        int d;
        d = (cur_debounce > 40) ? 40 : cur_debounce;
        return ($urandom_range(0, 4) == 0) ? d + 1 : d + 2 + $urandom_range(0, 2);
    endfunction

    task automatic hold_levels(input logic test_level, input logic start_level, input int n);
        repeat (n) send_tick(test_level, start_level, next_sample());
    endtask

    // Random button gestures: mostly clean presses, some bounce and long waits
    task automatic run_random(input int n_ticks);
        int stop_at;
        int r;
        int cap;
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at)
        begin
            r = $urandom_range(0, 15);
            if (r <= 3)
            begin
                sensor_style = sense_style_e'($urandom_range(0, 6));
                hold_levels(1'b0, 1'b1, press_len());
                hold_levels(1'b1, 1'b1, press_len());
            end
            else if (r <= 6)
            begin
                hold_levels(1'b1, 1'b0, press_len());
                hold_levels(1'b1, 1'b1, press_len());
            end
            else if (r == 7)
            begin
                sensor_style = sense_style_e'($urandom_range(0, 6));
                hold_levels(1'b0, 1'b0, press_len());
                hold_levels(1'b1, 1'b1, press_len());
            end
            else if (r <= 9)
            begin
                repeat ($urandom_range(1, 6))
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              next_sample());
            end
            else if (r <= 14)
            begin
                // long enough to finish a breath or a beep
                cap = 21 * cur_interval + ((cur_beep > 60) ? 60 : cur_beep);
                if (cap > 120)
                    cap = 120;
                hold_levels(1'b1, 1'b1, $urandom_range(1, cap));
            end
            else
                wait_idle();
        end
    endtask

    task automatic run_directed();
        // short warm-up, one-tick debounce, zero interval and zero period
        apply_settings(4095, 2, 0, 0, 0, 1, 2);
        // preheat ends on the third tick
        send_tick(1'b1, 1'b1, 12'hFFF);
        send_tick(1'b1, 1'b1, 12'h000);
        send_tick(1'b1, 1'b1, 12'hFFF);
        // test press from standby
        send_tick(1'b0, 1'b1, 12'h000);
        send_tick(1'b0, 1'b1, 12'hFFF);
        // twenty readings at the rails; a start press while sampling is ignored
        for (int i = 0; i < 20; i++)
            send_tick(1'b1, (i < 2) ? 1'b0 : 1'b1, (i % 2) ? 12'hFFF : 12'h000);
        // pass beep runs out
        send_tick(1'b1, 1'b1, 12'h800);
        send_tick(1'b1, 1'b1, 12'h7FF);
    endtask

    initial
    begin : stimulus
        chk = new();
        rst_n                 <= 1'b0;
        tick_if.valid         <= 1'b0;
        tick_if.test_level    <= 1'b1;
        tick_if.start_level   <= 1'b1;
        tick_if.sensor_sample <= '0;
        status_if.ready       <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        apply_settings(2000, 65535, 1, 1, 7, 3, 5);
        run_random(250);
        // always fail, buzzer never on, huge beep never reached
        apply_settings(0, 0, 2, 2, 1, 0, 65535);
        run_random(150);
        // almost always pass, no beep, buzzer always on in fail
        apply_settings(4095, 1, 0, 1, 65535, 65535, 0);
        run_random(200);
        // no level ever settles
        apply_settings(1000, 0, 65535, 65535, 500, 220, 180);
        run_random(100);
        apply_settings(THRESHOLD_RST, PREHEAT_RST, 3, 3, PERIOD_RST, ALARM_ON_RST, 10);
        run_random(300);
        repeat (3)
        begin
            apply_settings($urandom_range(0, 4095), $urandom_range(0, 65535),
                           $urandom_range(0, 4), $urandom_range(0, 3),
                           $urandom_range(0, 20), $urandom_range(0, 22),
                           $urandom_range(0, 20));
            run_random(120);
        end

        wait_idle();
        repeat (8) @(posedge clk);

        $display("%0d ticks under %0d register settings, %0d status requests checked",
                 ticks_sent, settings_applied, chk.checked);
        $display("breath verdicts: %0d pass, %0d fail; lock opened %0d times; %0d mismatches",
                 chk.passes, chk.fails, chk.unlocks, chk.mismatches);
        if (chk.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[breath_alcohol_interlock_controller.f]
design/baic_pkg.sv
design/baic_if.sv
design/breath_alcohol_interlock_controller.sv
dv/tb_top.sv
